// File: sv/bam_pkg.sv
// Shared types and constants for the buddy allocator block.
// No dependencies; used by the interfaces, the header RAM and the top level.
package bam_pkg;

  localparam int MAX_ORDER    = 16;
  localparam int MIN_ORDER    = 4;
  localparam int HEADER_BYTES = 16;

  localparam int SLOT_W  = MAX_ORDER - MIN_ORDER;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int OFF_W   = MAX_ORDER + 1;
  localparam int ORD_W   = 5;
  localparam int HDR_W   = ORD_W + 1;
  localparam int REQ_W   = 17;
  localparam int BOFF_W  = 16;
  localparam int CFG_W   = 5;
  localparam int NEED_W  = REQ_W + 1;

  localparam logic CFG_SPACE_ORDER = 1'b0;
  localparam logic CFG_FIT_MODE    = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_WREQ, S_WCHK, S_SPLIT, S_MREQ, S_MCHK, S_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [HDR_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: sv/bam_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on bam_pkg for field widths.
interface bam_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bam_pkg::REQ_W-1:0]    request_bytes;
  logic [bam_pkg::BOFF_W-1:0]   block_offset;
  modport source (output valid, action, request_bytes, block_offset, input ready);
  modport sink   (input valid, action, request_bytes, block_offset, output ready);
endinterface

interface bam_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [bam_pkg::BOFF_W-1:0]   result_offset;
  logic [bam_pkg::ORD_W-1:0]    result_order;
  modport source (output valid, status, result_offset, result_order, input ready);
  modport sink   (input valid, status, result_offset, result_order, output ready);
endinterface

// File: sv/buddy_allocator_fit_modes.sv
// Buddy allocator over a power-of-two pool, with first, best or worst fit.
// Depends on bam_pkg, bam_in_if, bam_out_if and bam_hdr_ram.
//
// Requests arrive on in_i (valid/ready); each gives exactly one result on
// out_o. An allocate walks the block headers in address order, a header
// read and then a check per block visited, then splits the chosen block
// one order at a time and marks it. A free walks to the target the same
// way, then merges with the free buddy, reading and checking the buddy's
// header for each merge. The walk visits blocks one at a time through the
// single read port of the header RAM. One request is in work at a time;
// the next is taken once the result has moved into the output register, so
// a stalled receiver holds one finished result while the block works on
// the next. Reset, and any write of space_order, enters an init state that
// writes the single free root block; in that state no request is taken.
// Headers of other slots are never read before written. Config writes are
// expected only while the block is idle.
module buddy_allocator_fit_modes (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [bam_pkg::CFG_W-1:0]   cfg_data_i,
  bam_in_if.sink                      in_i,
  bam_out_if.source                   out_o
);

  localparam int OW = bam_pkg::OFF_W;
  localparam int RW = bam_pkg::ORD_W;

  bam_pkg::state_e state_q, state_d;
  logic [RW-1:0]             space_q, space_d;
  logic [1:0]                fit_q, fit_d;
  logic                      action_q, action_d;
  logic [RW-1:0]             k_q, k_d;
  logic [OW-1:0]             target_q, target_d;
  logic [OW-1:0]             off_q, off_d;
  logic                      found_q, found_d;
  logic [OW-1:0]             pick_q, pick_d;
  logic [RW-1:0]             pord_q, pord_d;
  logic [RW-1:0]             o_q, o_d;
  logic [1:0]                rst_q, rst_d;
  logic [bam_pkg::BOFF_W-1:0] roff_q, roff_d;
  logic [RW-1:0]             rord_q, rord_d;
  logic                      ovalid_q, ovalid_d;
  logic [1:0]                ostat_q, ostat_d;
  logic [bam_pkg::BOFF_W-1:0] ooff_q, ooff_d;
  logic [RW-1:0]             oord_q, oord_d;

  bam_pkg::ram_req_t         ram_req;
  logic [bam_pkg::HDR_W-1:0] rdata;

  logic [OW-1:0]             pool;
  logic [RW-1:0]             hord;
  logic                      hocc;
  logic [OW-1:0]             nxt;
  logic                      take, first;
  logic [RW-1:0]             k_new;
  logic [bam_pkg::NEED_W-1:0] need;
  logic [RW-1:0]             cfg_clamped;
  logic [OW-1:0]             obit;
  logic [OW-1:0]             moff;
  logic [RW-1:0]             pord_m1;

  function automatic logic [bam_pkg::SLOT_W-1:0] slot_of(input logic [OW-1:0] off);
    slot_of = off[bam_pkg::MAX_ORDER-1:bam_pkg::MIN_ORDER];
  endfunction

  bam_hdr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // pool size, header decode with order clamp
  assign pool = OW'(1) << space_q;
  always_comb begin
    hocc = rdata[bam_pkg::HDR_W-1];
    hord = rdata[RW-1:0];
    if (hord < RW'(bam_pkg::MIN_ORDER)) hord = RW'(bam_pkg::MIN_ORDER);
    if (hord > space_q) hord = space_q;
  end
  assign nxt     = off_q + (OW'(1) << hord);
  assign obit    = OW'(1) << o_q;
  assign moff    = off_q & ~obit;
  assign pord_m1 = pord_q - RW'(1);

  // fit choice for the header under check
  assign first = (fit_q != bam_pkg::FIT_BEST) && (fit_q != bam_pkg::FIT_WORST);
  assign take  = !hocc && (hord >= k_q) &&
                 (!found_q ||
                  (fit_q == bam_pkg::FIT_BEST  && hord < pord_q) ||
                  (fit_q == bam_pkg::FIT_WORST && hord > pord_q));

  // needed order: smallest power of two holding request plus header
  always_comb begin
    need  = bam_pkg::NEED_W'(in_i.request_bytes) + bam_pkg::NEED_W'(bam_pkg::HEADER_BYTES);
    k_new = RW'(bam_pkg::NEED_W);
    for (int i = bam_pkg::NEED_W - 1; i >= bam_pkg::MIN_ORDER; i--) begin
      if ((bam_pkg::NEED_W'(1) << i) >= need) k_new = RW'(i);
    end
  end

  // clamp written space order
  always_comb begin
    cfg_clamped = cfg_data_i[RW-1:0];
    if (cfg_clamped < RW'(bam_pkg::MIN_ORDER)) cfg_clamped = RW'(bam_pkg::MIN_ORDER);
    if (cfg_clamped > RW'(bam_pkg::MAX_ORDER)) cfg_clamped = RW'(bam_pkg::MAX_ORDER);
  end

  assign in_i.ready = (state_q == bam_pkg::S_IDLE);

  // next state, RAM access and result capture
  always_comb begin
    state_d  = state_q;
    space_d  = space_q;
    fit_d    = fit_q;
    action_d = action_q;
    k_d      = k_q;
    target_d = target_q;
    off_d    = off_q;
    found_d  = found_q;
    pick_d   = pick_q;
    pord_d   = pord_q;
    o_d      = o_q;
    rst_d    = rst_q;
    roff_d   = roff_q;
    rord_d   = rord_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ostat_d  = ostat_q;
    ooff_d   = ooff_q;
    oord_d   = oord_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot_of(off_q);
    ram_req.wdata = '0;
    ram_req.raddr = slot_of(off_q);

    case (state_q)
      bam_pkg::S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = {1'b0, space_q};
        state_d       = bam_pkg::S_IDLE;
      end
      bam_pkg::S_IDLE: begin
        if (in_i.valid) begin
          action_d = in_i.action;
          k_d      = k_new;
          target_d = OW'(in_i.block_offset);
          off_d    = '0;
          found_d  = 1'b0;
          rst_d    = bam_pkg::ST_NOFIT;
          roff_d   = '0;
          rord_d   = '0;
          state_d  = bam_pkg::S_WREQ;
          if (in_i.action == bam_pkg::ACT_ALLOC) begin
            if (k_new > space_q) state_d = bam_pkg::S_DONE;
          end else begin
            rst_d = bam_pkg::ST_IGNORED;
            if (OW'(in_i.block_offset) >= pool) state_d = bam_pkg::S_DONE;
          end
        end
      end
      bam_pkg::S_WREQ: begin
        state_d = bam_pkg::S_WCHK;
      end
      bam_pkg::S_WCHK: begin
        if (action_q == bam_pkg::ACT_ALLOC) begin
          if (take) begin
            found_d = 1'b1;
            pick_d  = off_q;
            pord_d  = hord;
          end
          if (take && first) begin
            state_d = bam_pkg::S_SPLIT;
          end else if (nxt >= pool) begin
            state_d = (found_q || take) ? bam_pkg::S_SPLIT : bam_pkg::S_DONE;
          end else begin
            off_d   = nxt;
            state_d = bam_pkg::S_WREQ;
          end
        end else if (off_q == target_q) begin
          if (hocc) begin
            ram_req.we    = 1'b1;
            ram_req.wdata = {1'b0, hord};
            o_d    = hord;
            rst_d  = bam_pkg::ST_FREED;
            roff_d = off_q[bam_pkg::BOFF_W-1:0];
            rord_d = hord;
            state_d = (hord < space_q) ? bam_pkg::S_MREQ : bam_pkg::S_DONE;
          end else begin
            state_d = bam_pkg::S_DONE;
          end
        end else if (nxt > target_q) begin
          state_d = bam_pkg::S_DONE;
        end else begin
          off_d   = nxt;
          state_d = bam_pkg::S_WREQ;
        end
      end
      bam_pkg::S_SPLIT: begin
        ram_req.we = 1'b1;
        if (pord_q > k_q) begin
          pord_d        = pord_m1;
          ram_req.waddr = slot_of(pick_q + (OW'(1) << pord_m1));
          ram_req.wdata = {1'b0, pord_m1};
        end else begin
          ram_req.waddr = slot_of(pick_q);
          ram_req.wdata = {1'b1, k_q};
          rst_d   = bam_pkg::ST_ALLOC;
          roff_d  = pick_q[bam_pkg::BOFF_W-1:0];
          rord_d  = k_q;
          state_d = bam_pkg::S_DONE;
        end
      end
      bam_pkg::S_MREQ: begin
        ram_req.raddr = slot_of(off_q ^ obit);
        state_d       = bam_pkg::S_MCHK;
      end
      bam_pkg::S_MCHK: begin
        if (hocc || rdata[RW-1:0] != o_q) begin
          state_d = bam_pkg::S_DONE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = slot_of(moff);
          ram_req.wdata = {1'b0, o_q + RW'(1)};
          off_d  = moff;
          o_d    = o_q + RW'(1);
          roff_d = moff[bam_pkg::BOFF_W-1:0];
          rord_d = o_q + RW'(1);
          state_d = ((o_q + RW'(1)) < space_q) ? bam_pkg::S_MREQ : bam_pkg::S_DONE;
        end
      end
      bam_pkg::S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          ostat_d  = rst_q;
          ooff_d   = roff_q;
          oord_d   = rord_q;
          state_d  = bam_pkg::S_IDLE;
        end
      end
      default: state_d = bam_pkg::S_INIT;
    endcase

    // register writes; a new space order rebuilds the pool
    if (cfg_we_i) begin
      if (cfg_index_i == bam_pkg::CFG_SPACE_ORDER) begin
        space_d = cfg_clamped;
        state_d = bam_pkg::S_INIT;
      end else begin
        fit_d = cfg_data_i[1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bam_pkg::S_INIT;
      space_q  <= RW'(bam_pkg::MAX_ORDER);
      fit_q    <= bam_pkg::FIT_FIRST;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      space_q  <= space_d;
      fit_q    <= fit_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    k_q      <= k_d;
    target_q <= target_d;
    off_q    <= off_d;
    found_q  <= found_d;
    pick_q   <= pick_d;
    pord_q   <= pord_d;
    o_q      <= o_d;
    rst_q    <= rst_d;
    roff_q   <= roff_d;
    rord_q   <= rord_d;
    ostat_q  <= ostat_d;
    ooff_q   <= ooff_d;
    oord_q   <= oord_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = ostat_q;
  assign out_o.result_offset = ooff_q;
  assign out_o.result_order  = oord_q;

endmodule

// File: sv/bam_hdr_ram.sv
// Block header store: one 6-bit header per minimum-size slot.
// Synchronous write, registered read; depends on bam_pkg.
module bam_hdr_ram (
  input  logic                        clk_i,
  input  bam_pkg::ram_req_t           req_i,
  output logic [bam_pkg::HDR_W-1:0]   rdata_o
);

  logic [bam_pkg::HDR_W-1:0] mem [bam_pkg::SLOTS];
  logic [bam_pkg::HDR_W-1:0] rdata_q;

  // write one header, read one header per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
